/* rtl/core/mahp_pkg.sv */
`timescale 1ns / 1ps

package mahp_pkg;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned SKIP_W      = 28;

    localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
    localparam logic [15:0] ID3_PREFIX = 16'h4944;
    localparam logic [7:0]  ID3_LAST   = 8'h33;

    // Decoded version codes
    localparam logic [1:0] VER_MPEG1  = 2'd0;
    localparam logic [1:0] VER_MPEG2  = 2'd1;
    localparam logic [1:0] VER_MPEG25 = 2'd2;

    // Raw version bits of header byte two
    localparam logic [1:0] VBITS_25   = 2'd0;
    localparam logic [1:0] VBITS_RSVD = 2'd1;
    localparam logic [1:0] VBITS_2    = 2'd2;
    localparam logic [1:0] VBITS_1    = 2'd3;

    localparam logic [1:0] LAYER_1    = 2'd0;
    localparam logic [1:0] LAYER_2    = 2'd1;
    localparam logic [1:0] LAYER_3    = 2'd2;
    localparam logic [1:0] LAYER_RSVD = 2'd3;

    localparam logic [1:0] SRI_RSVD   = 2'd3;
    localparam logic [1:0] MODE_MONO  = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PREFIX,
        PH_SKIP3,
        PH_SIZE,
        PH_BODY,
        PH_HUNT,
        PH_HDR2,
        PH_HDR3,
        PH_HDR4,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [10:0] frame_samples;
        logic [1:0]  channels;
        logic [15:0] sample_rate;
        logic [1:0]  layer_index;
        logic [1:0]  mpeg_version;
    } t_result;

    function automatic logic [1:0] f_version(input logic [1:0] vbits);
        logic [1:0] v;
        unique case (vbits)
            VBITS_25: v = VER_MPEG25;
            VBITS_2:  v = VER_MPEG2;
            VBITS_1:  v = VER_MPEG1;
            default:  v = VER_MPEG1;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] f_base_rate(input logic [1:0] sri);
        logic [15:0] r;
        unique case (sri)
            2'd0:     r = 16'd44100;
            2'd1:     r = 16'd48000;
            2'd2:     r = 16'd32000;
            SRI_RSVD: r = 16'd0;
        endcase
        return r;
    endfunction

    // Version 1 halves the MPEG1 rate, version 2 quarters it
    function automatic logic [15:0] f_rate(input logic [1:0] ver, input logic [1:0] sri);
        logic [15:0] base;
        logic [15:0] r;
        base = f_base_rate(sri);
        unique case (ver)
            VER_MPEG1:  r = base;
            VER_MPEG2:  r = base >> 1;
            VER_MPEG25: r = base >> 2;
            default:    r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [10:0] f_spf(input logic [1:0] ver, input logic [1:0] lay);
        logic [10:0] s;
        unique case (lay)
            LAYER_1: s = 11'd384;
            LAYER_2: s = 11'd1152;
            LAYER_3: s = (ver == VER_MPEG1) ? 11'd1152 : 11'd576;
            default: s = 11'd0;
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/mpeg_audio_header_probe_core.sv */
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)                                tuser
// s_axis   in   [7:0] data_byte                                   start_req
// m_axis   out  [1:0] version [3:2] layer [19:4] rate             valid_res
//               [21:20] channels [32:22] frame_samples
//
// One byte per cycle while no result is stalled: an input register feeds the
// parser, whose result goes to an output register. A result becomes valid once
// its last byte has passed the input register and the parser into the output register.
// Synchronous active-low reset returns to waiting for a start beat.
// A stalled result holds the parser; the input register still takes one beat.

module mpeg_audio_header_probe_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [mahp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [7:0] data_byte
    input  logic                                  s_axis_tuser,  // start_req
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [mahp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // version, layer, rate,
                                                                 // channels, frame_samples
    output logic                                  m_axis_tuser   // valid_res
);

    import mahp_pkg::*;

    logic                    r_in_valid;
    logic [7:0]              r_in_byte;
    logic                    r_in_start;

    t_phase                  r_phase, n_phase;
    logic [2:0]              r_pos, n_pos;
    logic [SKIP_W-1:0]       r_skip, n_skip;
    logic [15:0]             r_prefix, n_prefix;
    logic [7:0]              r_hdr2, n_hdr2;
    logic [7:0]              r_hdr3, n_hdr3;

    logic                    r_out_valid;
    t_result                 r_res;
    logic                    r_res_ok;

    logic                    w_proc;
    logic                    w_emit;
    logic [1:0]              w_vbits;
    logic [1:0]              w_ver;
    logic [1:0]              w_lay;
    logic [15:0]             w_rate;
    t_result                 w_res;

    assign w_proc        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    // Header decode from the two stored bytes and the current (fourth) byte
    always_comb begin
        w_vbits                 = r_hdr2[4:3];
        w_ver                   = f_version(w_vbits);
        w_lay                   = 2'd3 - r_hdr2[2:1];
        w_rate                  = (w_vbits == VBITS_RSVD) ? 16'd0
                                                          : f_rate(w_ver, r_hdr3[3:2]);
        w_res.mpeg_version      = w_ver;
        w_res.layer_index       = w_lay;
        w_res.sample_rate       = w_rate;
        w_res.channels          = (r_in_byte[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
        w_res.frame_samples     = f_spf(w_ver, w_lay);
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_skip   = r_skip;
        n_prefix = r_prefix;
        n_hdr2   = r_hdr2;
        n_hdr3   = r_hdr3;
        w_emit   = 1'b0;
        if (r_in_start) begin
            n_phase  = PH_PREFIX;
            n_prefix = {8'h00, r_in_byte};
            n_pos    = 3'd1;
            n_skip   = '0;
        end else begin
            unique case (r_phase)
                PH_PREFIX: begin
                    if (r_pos == 3'd1) begin
                        n_prefix = {r_prefix[7:0], r_in_byte};
                        n_pos    = 3'd2;
                    end else begin
                        n_pos = 3'd0;
                        if (r_prefix == ID3_PREFIX && r_in_byte == ID3_LAST) begin
                            n_phase = PH_SKIP3;
                        end else begin
                            // replay the three prefix bytes through the sync hunt
                            priority if (r_prefix[15:8] == SYNC_BYTE) begin
                                n_hdr2  = r_prefix[7:0];
                                n_hdr3  = r_in_byte;
                                n_phase = PH_HDR4;
                            end else if (r_prefix[7:0] == SYNC_BYTE) begin
                                n_hdr2  = r_in_byte;
                                n_phase = PH_HDR3;
                            end else if (r_in_byte == SYNC_BYTE) begin
                                n_phase = PH_HDR2;
                            end else begin
                                n_phase = PH_HUNT;
                            end
                        end
                    end
                end
                PH_SKIP3: begin
                    n_pos = r_pos + 3'd1;
                    if (n_pos >= 3'd3) begin
                        n_pos   = 3'd0;
                        n_skip  = '0;
                        n_phase = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    n_skip = {r_skip[SKIP_W-8:0], r_in_byte[6:0]};
                    n_pos  = r_pos + 3'd1;
                    if (n_pos >= 3'd4) begin
                        n_pos   = 3'd0;
                        n_phase = (n_skip == '0) ? PH_HUNT : PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_skip = r_skip - SKIP_W'(1);
                    if (n_skip == '0) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_HUNT: begin
                    if (r_in_byte == SYNC_BYTE) begin
                        n_phase = PH_HDR2;
                    end
                end
                PH_HDR2: begin
                    n_hdr2  = r_in_byte;
                    n_phase = PH_HDR3;
                end
                PH_HDR3: begin
                    n_hdr3  = r_in_byte;
                    n_phase = PH_HDR4;
                end
                PH_HDR4: begin
                    w_emit  = 1'b1;
                    n_phase = PH_DONE;
                end
                PH_IDLE, PH_DONE: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pos    <= 3'd0;
            r_skip   <= '0;
            r_prefix <= '0;
            r_hdr2   <= '0;
            r_hdr3   <= '0;
        end else if (w_proc) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_skip   <= n_skip;
            r_prefix <= n_prefix;
            r_hdr2   <= n_hdr2;
            r_hdr3   <= n_hdr3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_proc && w_emit) begin
            r_res    <= w_res;
            r_res_ok <= (w_rate != 16'd0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_res_ok;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_res};

    a_result_after_hdr4 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> r_phase == PH_DONE)
        else $error("result beat without a completed header");

    a_valid_matches_rate : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[19:4] != 16'd0)))
        else $error("valid_res disagrees with sample_rate");

    a_channels_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[21:20] == 2'd1 || m_axis_tdata[21:20] == 2'd2))
        else $error("channel count out of range");

    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_proc) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost a stalled beat");

endmodule
